### rtl/tga_pixel_stream_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// TGA pixel stream decoder - assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TGA_PIXEL_STREAM_DECODER_UNIT_DEFINES_SVH
`define TGA_PIXEL_STREAM_DECODER_UNIT_DEFINES_SVH

// property must hold at every edge
`define TGAPSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define TGAPSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TGAPSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tgapsd_pkg.sv
// ----------------------------------------------------------------------------
// TGA pixel stream decoder - package
// Payload structs, register map, image kind and error codes.
// ----------------------------------------------------------------------------
package tgapsd_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned CFG_AW            = 4;
  localparam int unsigned CFG_DW            = 32;

  // run packet header
  localparam int unsigned RUN_FLAG_BIT   = 7;
  localparam logic [6:0]  RUN_COUNT_MASK = 7'h7F;

  // register indexes
  localparam logic [1:0] REG_IMAGE_KIND = 2'd0;
  localparam logic [1:0] REG_FOUR_BYTE  = 2'd1;
  localparam logic [1:0] REG_PIX_TOTAL  = 2'd2;

  typedef enum logic [1:0] {
    KIND_INDEXED = 2'd0,
    KIND_RAW     = 2'd1,
    KIND_RLE     = 2'd2
  } image_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_EARLY_END = 2'd2
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       mode;
    logic       start_image;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_res;
    logic       last_pixel;
    logic [1:0] error;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  image_kind;
    logic        four_byte_pixels;
    logic [31:0] pixel_total;
  } cfg_t;

  // one finished pixel (or error) in file byte order, between front and back
  typedef struct packed {
    logic [31:0] px;
    logic        four;
    logic [7:0]  rep;
    logic        last;
    logic [1:0]  err;
  } pix_cmd_t;

endpackage

### rtl/tgapsd_regs.sv
// ----------------------------------------------------------------------------
// TGA pixel stream decoder - configuration registers
// APB-style register file: image kind, pixel size, pixel total.
// ----------------------------------------------------------------------------
module tgapsd_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tgapsd_pkg::CFG_AW-1:0]     paddr,
  input  logic [tgapsd_pkg::CFG_DW-1:0]     pwdata,
  output logic [tgapsd_pkg::CFG_DW-1:0]     prdata,
  output logic                              pready,
  output tgapsd_pkg::cfg_t                  cfg_o
);

  tgapsd_pkg::cfg_t cfg_q, cfg_d;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        tgapsd_pkg::REG_IMAGE_KIND: cfg_d.image_kind       = pwdata[1:0];
        tgapsd_pkg::REG_FOUR_BYTE:  cfg_d.four_byte_pixels = pwdata[0];
        tgapsd_pkg::REG_PIX_TOTAL:  cfg_d.pixel_total      = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_kind       <= tgapsd_pkg::KIND_RAW;
      cfg_q.four_byte_pixels <= 1'b0;
      cfg_q.pixel_total      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      tgapsd_pkg::REG_IMAGE_KIND: prdata = {30'b0, cfg_q.image_kind};
      tgapsd_pkg::REG_FOUR_BYTE:  prdata = {31'b0, cfg_q.four_byte_pixels};
      tgapsd_pkg::REG_PIX_TOTAL:  prdata = cfg_q.pixel_total;
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/tgapsd_front.sv
// ----------------------------------------------------------------------------
// TGA pixel stream decoder - front end
// Takes one byte per cycle while full_o is low, tracks assembly, runs and pixel
// count, owns the palette memory, and queues finished pixels and errors.
// ----------------------------------------------------------------------------
`include "tga_pixel_stream_decoder_unit_defines.svh"

module tgapsd_front #(
  parameter int unsigned PALETTE_DEPTH = tgapsd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  tgapsd_pkg::in_item_t  item_i,
  input  tgapsd_pkg::cfg_t      cfg_i,
  output logic                  q_push_o,
  output tgapsd_pkg::pix_cmd_t  q_cmd_o,
  input  logic                  q_full_i
);

  localparam int unsigned AddrW = $clog2(PALETTE_DEPTH);
  localparam int unsigned FillW = $clog2(PALETTE_DEPTH + 1);

  // per-image state
  logic [FillW-1:0] fill_q, fill_d, fill_e;
  logic [1:0]       idx_q, idx_d, idx_e;
  logic [31:0]      asm_q, asm_d, asm_e;
  logic [7:0]       rem_q, rem_d, rem_e;
  logic             rrep_q, rrep_d, rrep_e;
  logic [31:0]      done_q, done_d, done_e;
  logic             stop_q, stop_d, stop_e;

  // stage register toward the queue
  logic                 s1_valid_q;
  logic                 s1_pal_q;
  tgapsd_pkg::pix_cmd_t s1_q;

  logic                 accept;
  logic                 res_v, res_pal;
  tgapsd_pkg::pix_cmd_t res;

  logic [7:0]  b;
  logic [1:0]  tb_last, tb_idx;
  logic        tb_done;
  logic [31:0] tb_asm;
  logic        active;
  logic [7:0]  run_cnt;
  logic        emit;
  logic [7:0]  emit_rep;
  logic [31:0] emit_px;
  logic [31:0] sum;
  logic        pal_we, pal_re, in_range;

  // palette memory with per-entry valid bits (unwritten entries read zero)
  logic [31:0]              pal_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] pal_vld_q;
  logic [31:0]              rd_q;
  logic                     rd_ok_q;

  assign full_o   = s1_valid_q && q_full_i;
  assign accept   = push_i && !full_o;
  assign q_push_o = s1_valid_q && !q_full_i;
  assign b        = item_i.data_byte;
  assign in_range = {1'b0, b} < 9'(PALETTE_DEPTH);

  always_comb begin
    if (item_i.start_image) begin
      fill_e = '0;
      idx_e  = '0;
      asm_e  = '0;
      rem_e  = '0;
      rrep_e = 1'b0;
      done_e = '0;
      stop_e = 1'b0;
    end else begin
      fill_e = fill_q;
      idx_e  = idx_q;
      asm_e  = asm_q;
      rem_e  = rem_q;
      rrep_e = rrep_q;
      done_e = done_q;
      stop_e = stop_q;
    end

    tb_last = cfg_i.four_byte_pixels ? 2'd3 : 2'd2;
    tb_asm  = asm_e | ({24'b0, b} << {idx_e, 3'b000});
    tb_done = idx_e >= tb_last;
    tb_idx  = tb_done ? 2'd0 : idx_e + 2'd1;

    active  = !stop_e && (done_e < cfg_i.pixel_total);
    run_cnt = {1'b0, b[6:0] & tgapsd_pkg::RUN_COUNT_MASK} + 8'd1;

    fill_d   = fill_e;
    idx_d    = idx_e;
    asm_d    = asm_e;
    rem_d    = rem_e;
    rrep_d   = rrep_e;
    stop_d   = stop_e;
    emit     = 1'b0;
    emit_rep = 8'd1;
    emit_px  = tb_asm;
    res_v    = 1'b0;
    res_pal  = 1'b0;
    res      = '0;
    pal_we   = 1'b0;
    pal_re   = 1'b0;

    if (!item_i.mode) begin
      idx_d = tb_idx;
      asm_d = tb_done ? '0 : tb_asm;
      if (tb_done && (fill_e < FillW'(PALETTE_DEPTH))) begin
        pal_we = 1'b1;
        fill_d = fill_e + FillW'(1);
      end
    end else if (active) begin
      case (cfg_i.image_kind)
        tgapsd_pkg::KIND_INDEXED: begin
          pal_re  = 1'b1;
          res_pal = 1'b1;
          emit    = 1'b1;
        end
        tgapsd_pkg::KIND_RLE: begin
          if (rem_e == 8'd0) begin
            if ({1'b0, done_e} + {25'b0, run_cnt} > {1'b0, cfg_i.pixel_total}) begin
              res_v     = 1'b1;
              res.err   = tgapsd_pkg::ERR_OVERFLOW;
              stop_d    = 1'b1;
            end else begin
              rem_d  = run_cnt;
              rrep_d = b[tgapsd_pkg::RUN_FLAG_BIT];
              idx_d  = '0;
              asm_d  = '0;
            end
          end else begin
            idx_d = tb_idx;
            asm_d = tb_done ? '0 : tb_asm;
            if (tb_done) begin
              emit     = 1'b1;
              emit_rep = rrep_e ? rem_e : 8'd1;
              rem_d    = rrep_e ? 8'd0 : rem_e - 8'd1;
            end
          end
        end
        default: begin
          // raw pixels, also the undefined kind
          idx_d = tb_idx;
          asm_d = tb_done ? '0 : tb_asm;
          emit  = tb_done;
        end
      endcase
    end

    sum    = done_e + {24'b0, emit_rep};
    done_d = emit ? sum : done_e;

    if (emit) begin
      res_v    = 1'b1;
      res.px   = res_pal ? '0 : emit_px;
      res.rep  = emit_rep;
      res.last = (sum == cfg_i.pixel_total);
    end
    res.four = cfg_i.four_byte_pixels;

    // early end of data
    if (item_i.end_of_data && !stop_d && (done_d < cfg_i.pixel_total)) begin
      res_v   = 1'b1;
      res.err = tgapsd_pkg::ERR_EARLY_END;
      stop_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      idx_q      <= '0;
      asm_q      <= '0;
      rem_q      <= '0;
      rrep_q     <= 1'b0;
      done_q     <= '0;
      stop_q     <= 1'b0;
      s1_valid_q <= 1'b0;
      s1_pal_q   <= 1'b0;
    end else if (accept) begin
      fill_q     <= fill_d;
      idx_q      <= idx_d;
      asm_q      <= asm_d;
      rem_q      <= rem_d;
      rrep_q     <= rrep_d;
      done_q     <= done_d;
      stop_q     <= stop_d;
      s1_valid_q <= res_v;
      s1_pal_q   <= res_pal;
    end else if (q_push_o) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= res;
    end
  end

  // palette storage: written on a finished palette entry, read by an index byte
  always_ff @(posedge clk_i) begin
    if (accept && pal_we) begin
      pal_mem[fill_e[AddrW-1:0]] <= tb_asm;
    end
    if (accept && pal_re) begin
      rd_q <= pal_mem[b[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (accept && pal_we) begin
        pal_vld_q[fill_e[AddrW-1:0]] <= 1'b1;
      end
      if (accept && pal_re) begin
        rd_ok_q <= in_range && pal_vld_q[b[AddrW-1:0]];
      end
    end
  end

  always_comb begin
    q_cmd_o = s1_q;
    if (s1_pal_q) begin
      q_cmd_o.px = rd_ok_q ? rd_q : '0;
    end
  end

  `TGAPSD_ASSERT_NXT(a_start_clears_count, accept && item_i.start_image && !item_i.mode,
                     done_q == 32'd0, "pixel count not cleared by start of image")
  `TGAPSD_ASSERT_IMP(a_overflow_stops, s1_valid_q && s1_q.err == tgapsd_pkg::ERR_OVERFLOW,
                     stop_q, "run overflow pending without stopped decoder")

endmodule

### rtl/tgapsd_fifo.sv
// ----------------------------------------------------------------------------
// TGA pixel stream decoder - command queue
// Short queue of pixel commands between front end and back end.
// ----------------------------------------------------------------------------
`include "tga_pixel_stream_decoder_unit_defines.svh"

module tgapsd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tgapsd_pkg::pix_cmd_t  wdata_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output tgapsd_pkg::pix_cmd_t  rdata_o,
  output logic                  empty_o
);

  localparam int unsigned Depth = tgapsd_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tgapsd_pkg::pix_cmd_t store_q [Depth];
  logic [PtrW-1:0]      wptr_q, rptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = store_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `TGAPSD_ASSERT(a_count_bound, cnt_q <= CntW'(Depth), "queue count past depth")

endmodule

### rtl/tgapsd_back.sv
// ----------------------------------------------------------------------------
// TGA pixel stream decoder - back end
// Reorders pixel bytes to red-green-blue-alpha and holds the result register.
// ----------------------------------------------------------------------------
`include "tga_pixel_stream_decoder_unit_defines.svh"

module tgapsd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  tgapsd_pkg::pix_cmd_t  q_cmd_i,
  output logic                  q_pop_o,
  output logic                  empty,
  input  logic                  pop,
  output tgapsd_pkg::out_item_t res_o
);

  logic                  vld_q;
  tgapsd_pkg::out_item_t res_q, res_d;

  assign q_pop_o = !q_empty_i && (!vld_q || pop);
  assign empty   = !vld_q;
  assign res_o   = res_q;

  always_comb begin
    res_d.red        = q_cmd_i.px[23:16];
    res_d.green      = q_cmd_i.px[15:8];
    res_d.blue       = q_cmd_i.px[7:0];
    res_d.alpha      = q_cmd_i.four ? q_cmd_i.px[31:24] : 8'd0;
    res_d.repeat_res = q_cmd_i.rep;
    res_d.last_pixel = q_cmd_i.last;
    res_d.error      = q_cmd_i.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (q_pop_o) begin
      vld_q <= 1'b1;
    end else if (pop) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  `TGAPSD_ASSERT_IMP(a_zero_rep_is_error, vld_q && res_q.repeat_res == 8'd0,
                     res_q.error != tgapsd_pkg::ERR_NONE, "zero repeat without error")

endmodule

### rtl/tga_pixel_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// TGA pixel stream decoder - top level
// Decodes indexed, raw and run-length TGA body bytes into RGBA pixels with
// repeat counts; flags run overflow and early end of data.
// ----------------------------------------------------------------------------
//  Port group       Direction  Transfer condition
//  push/full/data_i in         push && !full
//  empty/pop/res_o  out        pop && !empty
//  APB (p*)         cfg        psel && penable && pwrite (pready tied high)
//
//  One byte is taken per cycle while full is low, in every image kind.
//  On its way to the output a result passes the front stage register (which
//  also holds the palette read), the command queue, and the output register.
//  Reset clears all control state and the palette valid bits at once; no
//  sweep is needed, the first byte may be pushed right after reset.
//  With pop held low, full rises once the output register holds a result, the
//  queue is full and the front stage holds a result.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_unit #(
  parameter int unsigned PALETTE_DEPTH = tgapsd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  tgapsd_pkg::in_item_t          data_i,
  output logic                          empty,
  input  logic                          pop,
  output tgapsd_pkg::out_item_t         res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tgapsd_pkg::CFG_AW-1:0] paddr,
  input  logic [tgapsd_pkg::CFG_DW-1:0] pwdata,
  output logic [tgapsd_pkg::CFG_DW-1:0] prdata,
  output logic                          pready
);

  tgapsd_pkg::cfg_t     cfg;
  tgapsd_pkg::pix_cmd_t q_wdata, q_rdata;
  logic                 q_push, q_full, q_pop, q_empty;

  tgapsd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tgapsd_front #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .item_i   (data_i),
    .cfg_i    (cfg),
    .q_push_o (q_push),
    .q_cmd_o  (q_wdata),
    .q_full_i (q_full)
  );

  tgapsd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  tgapsd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_rdata),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_o)
  );

endmodule

### dv/tga_pixel_stream_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// TGA pixel stream decoder - testbench
// Drives palette and image bytes through the push/full queue port and
// programs the registers over APB. A cycle-free model of the decoder predicts
// each pixel or error, and every popped result is compared field by field.
// ----------------------------------------------------------------------------
module tga_pixel_stream_decoder_unit_tb;

  localparam logic        MODE_PAL      = 1'b0;
  localparam logic        MODE_IMG      = 1'b1;
  localparam logic [31:0] PIX_TOTAL_MAX = 32'hFFFE0001;
  localparam int          SETTLE_CYCLES = 8;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             push;
  logic                             full;
  tgapsd_pkg::in_item_t             data_i;
  logic                             empty;
  logic                             pop;
  tgapsd_pkg::out_item_t            res_o;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [tgapsd_pkg::CFG_AW-1:0]    paddr;
  logic [tgapsd_pkg::CFG_DW-1:0]    pwdata;
  logic [tgapsd_pkg::CFG_DW-1:0]    prdata;
  logic                             pready;

  // decoder model state
  logic [1:0]  cfg_kind;
  logic        cfg_four;
  logic [31:0] cfg_total;
  logic [31:0] pal_mem [tgapsd_pkg::PALETTE_DEPTH_DEF];
  int unsigned pal_fill;
  logic [1:0]  byte_pos;
  logic [31:0] pix_acc;
  logic [7:0]  run_left;
  logic        run_rep;
  logic [31:0] done_cnt;
  logic        halted;

  tgapsd_pkg::out_item_t pixel_q[$];
  tgapsd_pkg::in_item_t  img_q[$];
  int        err_count   = 0;
  int        items_sent  = 0;
  int        pop_hold    = 0;
  bit        gaps_on     = 1'b1;

  tga_pixel_stream_decoder_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .data_i  (data_i),
    .empty   (empty),
    .pop     (pop),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------- model --
  function automatic void clear_image_state();
    pal_fill = 0;
    byte_pos = 2'd0;
    pix_acc  = 32'h0;
    run_left = 8'd0;
    run_rep  = 1'b0;
    done_cnt = 32'h0;
    halted   = 1'b0;
  endfunction

  // palette and pixel assembly share one byte position
  function automatic bit gather_byte(input logic [7:0] b);
    pix_acc |= 32'(b) << (8 * byte_pos);
    if (byte_pos >= (cfg_four ? 2'd3 : 2'd2)) begin
      byte_pos = 2'd0;
      return 1'b1;
    end
    byte_pos = byte_pos + 2'd1;
    return 1'b0;
  endfunction

  function automatic tgapsd_pkg::out_item_t make_pixel(input logic [31:0] px,
                                                       input logic [7:0] rep);
    tgapsd_pkg::out_item_t r;
    r            = '0;
    r.red        = px[23:16];
    r.green      = px[15:8];
    r.blue       = px[7:0];
    r.alpha      = cfg_four ? px[31:24] : 8'h00;
    r.repeat_res = rep;
    done_cnt     = done_cnt + 32'(rep);
    r.last_pixel = (done_cnt == cfg_total);
    return r;
  endfunction

  function automatic void decode_byte(input tgapsd_pkg::in_item_t it);
    tgapsd_pkg::out_item_t r;
    bit                    have;
    logic [32:0]           cnt;
    r    = '0;
    have = 1'b0;
    if (it.start_image) clear_image_state();
    if (it.mode == MODE_PAL) begin
      if (gather_byte(it.data_byte)) begin
        if (pal_fill < tgapsd_pkg::PALETTE_DEPTH_DEF) begin
          pal_mem[pal_fill] = pix_acc;
          pal_fill++;
        end
        pix_acc = 32'h0;
      end
    end else if (!halted && done_cnt < cfg_total) begin
      if (cfg_kind == tgapsd_pkg::KIND_INDEXED) begin
        r    = make_pixel(pal_mem[it.data_byte], 8'd1);
        have = 1'b1;
      end else if (cfg_kind == tgapsd_pkg::KIND_RLE) begin
        if (run_left == 8'd0) begin
          cnt = 33'(it.data_byte[6:0]) + 33'd1;
          if (33'(done_cnt) + cnt > 33'(cfg_total)) begin
            r.error = tgapsd_pkg::ERR_OVERFLOW;
            halted  = 1'b1;
            have    = 1'b1;
          end else begin
            run_left = 8'(cnt);
            run_rep  = it.data_byte[tgapsd_pkg::RUN_FLAG_BIT];
            byte_pos = 2'd0;
            pix_acc  = 32'h0;
          end
        end else if (gather_byte(it.data_byte)) begin
          if (run_rep) begin
            r        = make_pixel(pix_acc, run_left);
            run_left = 8'd0;
          end else begin
            r        = make_pixel(pix_acc, 8'd1);
            run_left = run_left - 8'd1;
          end
          pix_acc = 32'h0;
          have    = 1'b1;
        end
      end else if (gather_byte(it.data_byte)) begin
        // raw, and the undefined kind 3 as well
        r       = make_pixel(pix_acc, 8'd1);
        pix_acc = 32'h0;
        have    = 1'b1;
      end
    end
    if (it.end_of_data && !halted && done_cnt < cfg_total) begin
      r.error = tgapsd_pkg::ERR_EARLY_END;
      halted  = 1'b1;
      have    = 1'b1;
    end
    if (have) pixel_q = {pixel_q, r};
  endfunction

  // ------------------------------------------------------------- checking --
  function automatic void cmp_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  function automatic void check_pixel(input tgapsd_pkg::out_item_t got);
    tgapsd_pkg::out_item_t want;
    if (pixel_q.size() == 0) begin
      $display("%0t: result with nothing expected, got %p", $time, got);
      err_count++;
    end else begin
      want = pixel_q.pop_front();
      cmp_field("red", want.red, got.red);
      cmp_field("green", want.green, got.green);
      cmp_field("blue", want.blue, got.blue);
      cmp_field("alpha", want.alpha, got.alpha);
      cmp_field("repeat_res", want.repeat_res, got.repeat_res);
      cmp_field("last_pixel", 8'(want.last_pixel), 8'(got.last_pixel));
      cmp_field("error", 8'(want.error), 8'(got.error));
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_pixel(res_o);
  end

  // ---------------------------------------------------------- result side --
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  initial begin : pop_driver
    int stall;
    stall = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // ----------------------------------------------------------- input side --
  function automatic tgapsd_pkg::in_item_t item(input logic [7:0] b, input logic m,
                                                input logic st, input logic eod);
    tgapsd_pkg::in_item_t it;
    it.data_byte   = b;
    it.mode        = m;
    it.start_image = st;
    it.end_of_data = eod;
    return it;
  endfunction

  function automatic void queue_byte(input tgapsd_pkg::in_item_t it);
    img_q = {img_q, it};
  endfunction

  task automatic send_byte(input tgapsd_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push   <= 1'b1;
    data_i <= it;
    do @(posedge clk_i); while (full);
    decode_byte(it);
    items_sent++;
  endtask

  // no result may be pending, and bytes without a result may still be in flight
  task automatic wait_idle();
    push <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd_want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tgapsd_pkg::CFG_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      tgapsd_pkg::REG_IMAGE_KIND: begin
        cfg_kind = val[1:0];
        rd_want  = {30'b0, val[1:0]};
      end
      tgapsd_pkg::REG_FOUR_BYTE: begin
        cfg_four = val[0];
        rd_want  = {31'b0, val[0]};
      end
      tgapsd_pkg::REG_PIX_TOTAL: begin
        cfg_total = val;
        rd_want   = val;
      end
      default: rd_want = 32'h0;
    endcase
    @(posedge clk_i);
    // address is still held, so the register reads back here
    if (pready !== 1'b1 || prdata !== rd_want) begin
      $display("%0t: register %0d readback mismatch, expected %0h, got %0h",
               $time, idx, rd_want, prdata);
      err_count++;
    end
  endtask

  task automatic set_config(input logic [1:0] kind, input logic four, input logic [31:0] total);
    wait_idle();
    cfg_write(tgapsd_pkg::REG_IMAGE_KIND, 32'(kind));
    cfg_write(tgapsd_pkg::REG_FOUR_BYTE, 32'(four));
    cfg_write(tgapsd_pkg::REG_PIX_TOTAL, total);
  endtask

  // one image in file order, with occasional damage and an uneven ending
  task automatic build_image(input logic [1:0] kind, input int npix);
    int bpp;
    int n_pal;
    int left;
    int cnt;
    int cut;
    int idx;
    bit rep;
    bpp   = cfg_four ? 4 : 3;
    n_pal = 0;
    img_q.delete();
    if (kind == tgapsd_pkg::KIND_INDEXED || $urandom_range(0, 7) == 0) begin
      n_pal = $urandom_range(0, 20);
      for (int i = 0; i < n_pal * bpp; i++)
        queue_byte(item(8'($urandom), MODE_PAL, 1'b0, 1'b0));
    end
    if (kind == tgapsd_pkg::KIND_INDEXED) begin
      for (int i = 0; i < npix; i++)
        queue_byte(item(($urandom_range(0, 3) == 0) ? 8'($urandom) :
                        8'($urandom_range(0, n_pal)), MODE_IMG, 1'b0, 1'b0));
    end else if (kind == tgapsd_pkg::KIND_RLE) begin
      left = npix;
      while (left > 0) begin
        cnt = $urandom_range(1, (left < 128) ? left : 128);
        if ($urandom_range(0, 11) == 0) begin
          cnt = left + $urandom_range(1, 4);
          if (cnt > 128) cnt = 128;
        end
        rep = $urandom_range(0, 1);
        queue_byte(item({rep, 7'(cnt - 1)}, MODE_IMG, 1'b0, 1'b0));
        for (int i = 0; i < (rep ? 1 : cnt) * bpp; i++)
          queue_byte(item(8'($urandom), MODE_IMG, 1'b0, 1'b0));
        left -= cnt;
      end
    end else begin
      for (int i = 0; i < npix * bpp; i++)
        queue_byte(item(8'($urandom), MODE_IMG, 1'b0, 1'b0));
    end
    if (img_q.size() == 0) queue_byte(item(8'($urandom), MODE_IMG, 1'b0, 1'b0));
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, 3);
      for (int i = 0; i < cut; i++) begin
        idx = $urandom_range(0, img_q.size() - 1);
        case ($urandom_range(0, 3))
          0: img_q[idx].mode        = ~img_q[idx].mode;
          1: img_q[idx].data_byte   = 8'($urandom);
          2: img_q[idx].start_image = 1'b1;
          default: img_q[idx].end_of_data = 1'b1;
        endcase
      end
    end
    img_q[0].start_image = 1'b1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: img_q[img_q.size() - 1].end_of_data = 1'b1;
      4, 5: begin
        cut = $urandom_range(1, img_q.size());
        while (img_q.size() > cut) void'(img_q.pop_back());
        img_q[img_q.size() - 1].end_of_data = 1'b1;
      end
      6: begin
        cut = $urandom_range(1, 5);
        for (int i = 0; i < cut; i++)
          queue_byte(item(8'($urandom), MODE_IMG, 1'b0, 1'b0));
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- tests --
  // reset values: raw pixels and an empty image, so image bytes are dropped
  task automatic test_empty_image();
    send_byte(item(8'hFF, MODE_IMG, 1'b1, 1'b0));
    send_byte(item(8'h00, MODE_IMG, 1'b0, 1'b1));
  endtask

  task automatic test_palette_lookup();
    set_config(tgapsd_pkg::KIND_INDEXED, 1'b1, 32'd4);
    send_byte(item(8'hFF, MODE_PAL, 1'b1, 1'b0));
    send_byte(item(8'h00, MODE_PAL, 1'b0, 1'b0));
    send_byte(item(8'hFF, MODE_PAL, 1'b0, 1'b0));
    send_byte(item(8'h00, MODE_PAL, 1'b0, 1'b0));
    send_byte(item(8'h12, MODE_PAL, 1'b0, 1'b0));
    send_byte(item(8'h34, MODE_PAL, 1'b0, 1'b0));
    send_byte(item(8'h56, MODE_PAL, 1'b0, 1'b0));
    send_byte(item(8'h78, MODE_PAL, 1'b0, 1'b0));
    send_byte(item(8'h00, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'h01, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'hFF, MODE_IMG, 1'b0, 1'b0));   // never written, reads zero
    send_byte(item(8'h01, MODE_IMG, 1'b0, 1'b1));   // completes image, no error
    send_byte(item(8'h00, MODE_IMG, 1'b0, 1'b0));   // past the end, ignored
    // entries stored with alpha, looked up as three-byte pixels
    set_config(tgapsd_pkg::KIND_INDEXED, 1'b0, 32'd2);
    send_byte(item(8'h00, MODE_IMG, 1'b1, 1'b0));
    send_byte(item(8'h01, MODE_IMG, 1'b0, 1'b0));
  endtask

  task automatic test_run_packets();
    set_config(tgapsd_pkg::KIND_RLE, 1'b0, 32'd130);
    send_byte(item(8'hFF, MODE_IMG, 1'b1, 1'b0));   // repeat run of 128
    send_byte(item(8'h01, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'h02, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'h03, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'h01, MODE_IMG, 1'b0, 1'b0));   // literal run of 2
    for (int i = 0; i < 6; i++)
      send_byte(item(8'(8'hA0 + i), MODE_IMG, 1'b0, 1'b0));
    // new image: repeat run of 128, then a run of 3 that passes the total,
    // then a byte that must be ignored
    send_byte(item(8'hFF, MODE_IMG, 1'b1, 1'b0));
    send_byte(item(8'hFF, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'h00, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'h7F, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'h82, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'hAA, MODE_IMG, 1'b0, 1'b0));
    // data ends inside a pixel
    send_byte(item(8'h00, MODE_IMG, 1'b1, 1'b0));
    send_byte(item(8'h10, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'h20, MODE_IMG, 1'b0, 1'b1));
  endtask

  // kind 3 decodes as raw; the early end lands on a finished pixel
  task automatic test_odd_kind_early_end();
    set_config(2'd3, 1'b1, PIX_TOTAL_MAX);
    send_byte(item(8'h11, MODE_IMG, 1'b1, 1'b0));
    send_byte(item(8'h22, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'h33, MODE_IMG, 1'b0, 1'b0));
    send_byte(item(8'hFF, MODE_IMG, 1'b0, 1'b1));
    send_byte(item(8'h5A, MODE_PAL, 1'b0, 1'b0));   // palette still taken when stopped
  endtask

  task automatic test_backpressure();
    set_config(tgapsd_pkg::KIND_RAW, 1'b0, 32'd50);
    gaps_on  = 1'b0;
    pop_hold = 300;
    for (int i = 0; i < 150; i++)
      send_byte(item(8'($urandom), MODE_IMG, i == 0, 1'b0));
    gaps_on = 1'b1;
    wait_idle();
  endtask

  task automatic test_random_images();
    int          base;
    int          r;
    int          npix;
    logic [1:0]  kind;
    logic [31:0] total;
    base = items_sent;
    while (items_sent - base < 1300) begin
      r    = $urandom_range(0, 19);
      kind = (r == 0) ? 2'd3 : 2'(r % 3);
      r    = $urandom_range(0, 99);
      if (r < 2) begin
        total = 32'd0;
        npix  = 4;
      end else if (r < 6) begin
        total = PIX_TOTAL_MAX;
        npix  = 10;
      end else if (kind == tgapsd_pkg::KIND_RLE && r < 20) begin
        total = $urandom_range(129, 200);
        npix  = total;
      end else begin
        total = $urandom_range(1, 24);
        npix  = total;
      end
      set_config(kind, 1'($urandom_range(0, 1)), total);
      gaps_on = ($urandom_range(0, 4) != 0);
      build_image(kind, npix);
      if (total == PIX_TOTAL_MAX) img_q[img_q.size() - 1].end_of_data = 1'b1;
      foreach (img_q[i]) send_byte(img_q[i]);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni  <= 1'b0;
    push    <= 1'b0;
    data_i  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cfg_kind  = tgapsd_pkg::KIND_RAW;
    cfg_four  = 1'b0;
    cfg_total = 32'h0;
    foreach (pal_mem[i]) pal_mem[i] = 32'h0;
    clear_image_state();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_image();
    test_palette_lookup();
    test_run_packets();
    test_odd_kind_early_end();
    test_backpressure();
    test_random_images();

    wait_idle();
    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
